[rtl/bsw_pkg.sv]
// bsw_pkg: shared constants, command codes and cell control/status types
// for the broadcast stride walker. No dependencies.
package bsw_pkg;

	localparam int MAX_DIMS_DEF    = 4;
	localparam int ADDR_BITS_DEF   = 24;
	localparam int EXTENT_BITS_DEF = 16;

	// three address streams: operand A, operand B, result
	localparam int NOPS   = 3;
	localparam int OP_A   = 0;
	localparam int OP_B   = 1;
	localparam int OP_OUT = 2;

	localparam int CMD_W     = 2;
	localparam int DIM_SEL_W = 2;
	localparam int DIMS_W    = 3;

	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STEP    = 2'd2;

	typedef struct packed {
		logic load;
		logic restart;
		logic advance;
		logic capture;
		logic active;
	} bsw_ctl_t;

	typedef struct packed {
		logic zero_ext;
		logic wrap;
	} bsw_sts_t;

endpackage

[rtl/bsw_cell.sv]
// bsw_cell: one dimension of the walker: descriptor, coordinate counter,
// per-stream product and one stage of the rippling offset sum. Uses bsw_pkg.
module bsw_cell import bsw_pkg::*; #(
	parameter int ADDR_BITS   = ADDR_BITS_DEF,
	parameter int EXTENT_BITS = EXTENT_BITS_DEF,
	parameter int SUM_W       = ADDR_BITS_DEF + EXTENT_BITS_DEF + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bsw_ctl_t                          ctl,
	input  logic [EXTENT_BITS-1:0]            extent_in,
	input  logic [NOPS-1:0][ADDR_BITS-1:0]    stride_in,
	output bsw_sts_t                          sts,
	input  logic                              in_vld,
	input  logic [NOPS-1:0][SUM_W-1:0]        in_sum,
	output logic                              out_vld,
	output logic [NOPS-1:0][SUM_W-1:0]        out_sum
);

	localparam int PROD_W = ADDR_BITS + EXTENT_BITS;

	logic [EXTENT_BITS-1:0]         extent_q;
	logic [NOPS-1:0][ADDR_BITS-1:0] stride_q;
	logic [EXTENT_BITS-1:0]         coord_q;
	logic [NOPS-1:0][PROD_W-1:0]    prod_s1;
	logic                           vld_q;
	logic [NOPS-1:0][SUM_W-1:0]     sum_q;
	logic [EXTENT_BITS:0]           next_coord;

	assign next_coord   = {1'b0, coord_q} + {{EXTENT_BITS{1'b0}}, 1'b1};
	// a stale coordinate at or past its extent also wraps with a carry
	assign sts.wrap     = next_coord >= {1'b0, extent_q};
	assign sts.zero_ext = extent_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_q <= '0;
			stride_q <= '0;
			coord_q  <= '0;
			vld_q    <= 1'b0;
		end else begin
			if (ctl.load) begin
				extent_q <= extent_in;
				stride_q <= stride_in;
			end
			if (ctl.restart) begin
				coord_q <= '0;
			end else if (ctl.advance) begin
				coord_q <= sts.wrap ? '0 : next_coord[EXTENT_BITS-1:0];
			end
			vld_q <= in_vld;
		end
	end

	// products use the coordinate before this step's advance
	always_ff @(posedge clk) begin
		for (int op = 0; op < NOPS; op++) begin
			if (ctl.capture) begin
				prod_s1[op] <= PROD_W'(coord_q) * PROD_W'(stride_q[op]);
			end
			if (in_vld) begin
				sum_q[op] <= in_sum[op] + (ctl.active ? SUM_W'(prod_s1[op]) : '0);
			end
		end
	end

	assign out_vld = vld_q;
	assign out_sum = sum_q;

endmodule

[rtl/broadcast_stride_walker.sv]
// broadcast_stride_walker: top level, a row of bsw_cell dimension cells,
// the odometer carry chain and the result register. Uses bsw_pkg, bsw_cell.
//
//  port group       | direction | handshake
//  -----------------+-----------+------------------------------------------
//  command item     | in        | start high and busy low at a clock edge
//  dims_in_use reg  | in        | cfg_wr_en high at a clock edge
//  result item      | out       | strobe high for one cycle, no back-pressure
//
// A step item is registered into the per-cell multiply, then its offset sum
// ripples through the cells one per cycle, then into the result register.
// busy is high while a step item is in the cell chain; load, restart and
// unused commands do not raise busy and give no result. Reset clears all
// descriptors, counters and dims_in_use to 1.
// The receiver cannot stall, so a result is never held.
module broadcast_stride_walker import bsw_pkg::*; #(
	parameter int MAX_DIMS    = MAX_DIMS_DEF,
	parameter int ADDR_BITS   = ADDR_BITS_DEF,
	parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [CMD_W-1:0]       cmd,
	input  logic [DIM_SEL_W-1:0]   dim_sel,
	input  logic [EXTENT_BITS-1:0] extent,
	input  logic [ADDR_BITS-1:0]   stride_a,
	input  logic [ADDR_BITS-1:0]   stride_b,
	input  logic [ADDR_BITS-1:0]   stride_out,
	input  logic                   cfg_wr_en,
	input  logic [DIMS_W-1:0]      cfg_wr_data,
	output logic                   strobe,
	output logic                   elem_valid,
	output logic [ADDR_BITS-1:0]   offset_a,
	output logic [ADDR_BITS-1:0]   offset_b,
	output logic [ADDR_BITS-1:0]   offset_out,
	output logic                   last_elem,
	output logic                   offset_overflow
);

	localparam int SUM_W = ADDR_BITS + EXTENT_BITS + $clog2(MAX_DIMS);

	logic [DIMS_W-1:0]               dims_q;
	logic                            finished_q;
	logic                            go_q;
	logic                            skip_q;
	logic                            last_q;
	logic                            strobe_q;
	logic                            elem_valid_q;
	logic [NOPS-1:0][ADDR_BITS-1:0]  offset_q;
	logic                            last_elem_q;
	logic                            ovf_q;

	logic                            accept;
	logic                            is_step;
	logic                            skip;
	logic                            adv;
	logic                            empty;
	logic                            ovf_any;
	logic [MAX_DIMS:0]               active;
	logic [MAX_DIMS-1:0]             ci;
	logic [MAX_DIMS:0]               co;
	logic [MAX_DIMS-1:0]             zero_ext;
	bsw_ctl_t                        ctl [MAX_DIMS];
	bsw_sts_t                        sts [MAX_DIMS];
	logic [MAX_DIMS:0]               chain_vld;
	logic [MAX_DIMS:0][NOPS-1:0][SUM_W-1:0] chain_sum;
	logic [NOPS-1:0][ADDR_BITS-1:0]  stride_in;

	assign stride_in[OP_A]   = stride_a;
	assign stride_in[OP_B]   = stride_b;
	assign stride_in[OP_OUT] = stride_out;

	assign busy    = |chain_vld;
	assign accept  = start & ~busy;
	assign is_step = accept && (cmd == CMD_STEP);
	assign skip    = empty | finished_q;
	assign adv     = is_step & ~skip;

	// dims_in_use of 0 acts as 1; values above MAX_DIMS saturate
	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			active[d]   = (d == 0) || (int'(dims_q) > d);
			zero_ext[d] = sts[d].zero_ext;
		end
		active[MAX_DIMS] = 1'b0;
	end

	assign empty = |(active[MAX_DIMS-1:0] & zero_ext);

	// odometer carry enters at the innermost active dimension
	always_comb begin
		co[MAX_DIMS] = 1'b0;
		for (int d = MAX_DIMS - 1; d >= 0; d--) begin
			ci[d] = active[d+1] ? co[d+1] : 1'b1;
			co[d] = ci[d] & sts[d].wrap;
		end
	end

	assign chain_vld[0] = go_q;
	assign chain_sum[0] = '0;

	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
		always_comb begin
			ctl[g].load    = accept && (cmd == CMD_LOAD) && (int'(dim_sel) == g);
			ctl[g].restart = accept && (cmd == CMD_RESTART);
			ctl[g].advance = adv & active[g] & ci[g];
			ctl[g].capture = is_step;
			ctl[g].active  = active[g];
		end

		bsw_cell #(
			.ADDR_BITS   (ADDR_BITS),
			.EXTENT_BITS (EXTENT_BITS),
			.SUM_W       (SUM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[g]),
			.extent_in (extent),
			.stride_in (stride_in),
			.sts       (sts[g]),
			.in_vld    (chain_vld[g]),
			.in_sum    (chain_sum[g]),
			.out_vld   (chain_vld[g+1]),
			.out_sum   (chain_sum[g+1])
		);
	end

	always_comb begin
		ovf_any = 1'b0;
		for (int op = 0; op < NOPS; op++) begin
			ovf_any = ovf_any | (|chain_sum[MAX_DIMS][op][SUM_W-1:ADDR_BITS]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q     <= DIMS_W'(1);
			finished_q <= 1'b0;
			go_q       <= 1'b0;
			skip_q     <= 1'b0;
			last_q     <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dims_q <= cfg_wr_data;
			end
			if (accept && (cmd == CMD_RESTART)) begin
				finished_q <= 1'b0;
			end else if (adv && co[0]) begin
				finished_q <= 1'b1;
			end
			go_q <= is_step;
			if (is_step) begin
				skip_q <= skip;
				last_q <= co[0];
			end
			strobe_q <= chain_vld[MAX_DIMS];
		end
	end

	// empty or exhausted walks answer with all fields zero
	always_ff @(posedge clk) begin
		if (chain_vld[MAX_DIMS]) begin
			elem_valid_q <= ~skip_q;
			for (int op = 0; op < NOPS; op++) begin
				offset_q[op] <= skip_q ? '0 : chain_sum[MAX_DIMS][op][ADDR_BITS-1:0];
			end
			last_elem_q <= ~skip_q & last_q;
			ovf_q       <= ~skip_q & ovf_any;
		end
	end

	assign strobe          = strobe_q;
	assign elem_valid      = elem_valid_q;
	assign offset_a        = offset_q[OP_A];
	assign offset_b        = offset_q[OP_B];
	assign offset_out      = offset_q[OP_OUT];
	assign last_elem       = last_elem_q;
	assign offset_overflow = ovf_q;

	a_step_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_STEP) |-> ##(MAX_DIMS+2) strobe)
		else $error("step item did not return a result on time");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld))
		else $error("more than one step item in the cell chain");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result shown while the chain is still busy");

	a_last_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_elem) |-> finished_q)
		else $error("last element delivered but walk not marked finished");

endmodule
